// File: design/mf3_pkg.sv
// Shared types and constants of the 3x3 median filter.
`timescale 1ns / 1ps

package mf3_pkg;

    // Pixel and position widths
    localparam int PIX_W   = 8;
    localparam int ROW_W   = 11;
    localparam int CTR_W   = 11;
    localparam int CFG_W   = 12;

    // Line length limits
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int MIN_WIDTH     = 3;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 12'd640;

    // Register file: one 32-bit register per word
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_IMAGE_WIDTH = 1'b0;

    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [CTR_W-1:0]  ctr_t;
    typedef logic [CFG_W-1:0]  cfg_width_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [DATA_W-1:0] data_t;

    // One column of three pixels, sorted
    typedef struct packed {
        pix_t lo;
        pix_t mi;
        pix_t hi;
    } col3_t;

endpackage

// File: design/median_filter_3x3.sv
// Top level of the 3x3 median filter: line buffer, window and median pipeline.
`timescale 1ns / 1ps

// 3x3 median filter over a raster stream of 8-bit grey pixels. One pixel is
// taken per clock, sustained, while med_stall does not hold the pipeline; the
// line buffer is a single RAM of MAX_WIDTH x 16 bits holding the two previous rows,
// which is read when a pixel is taken and written back when that pixel leaves
// stage 1. A write and a read of the same column in the same cycle are resolved
// by forwarding. A result passes stages 1, 2 and 3 and then the output register.
// Pixels on the top two rows and the left two columns give no result; every
// other pixel gives the median of the window ending at it, tagged with the
// row and column of the window centre. frame_start restarts at row 0, column
// 0; rows wrap after 2048. image_width (APB, address 0) is clamped to
// 3..MAX_WIDTH and should be changed only between frames, with the filter
// idle. The line buffer is not cleared; there is no start-up sweep.
module median_filter_3x3
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,

    // APB register port
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  mf3_pkg::addr_t paddr,
    input  mf3_pkg::data_t pwdata,
    output mf3_pkg::data_t prdata,
    output logic           pready,

    // Pixel stream
    input  logic           pix_valid,
    output logic           pix_stall,
    input  mf3_pkg::pix_t  pixel,
    input  logic           frame_start,

    // Median stream
    output logic           med_valid,
    input  logic           med_stall,
    output mf3_pkg::pix_t  median_value,
    output mf3_pkg::row_t  center_row,
    output mf3_pkg::ctr_t  center_col
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int EW    = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic pix_t min2(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t max2(input pix_t a, input pix_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic col3_t sort3(input pix_t a, input pix_t b, input pix_t c);
        col3_t r;
        r.lo = min2(min2(a, b), c);
        r.hi = max2(max2(a, b), c);
        r.mi = med3(a, b, c);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    cfg_width_t width_reg;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[ADDR_W-1];

    // Write the width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_sel)
                REG_IMAGE_WIDTH: width_reg <= pwdata[CFG_W-1:0];
                default:         ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_sel)
            REG_IMAGE_WIDTH: prdata = DATA_W'(width_reg);
            default:         prdata = '0;
        endcase
    end

    // Clamp the width to the supported range
    logic [EW-1:0] cfg_w;
    logic [EW-1:0] eff_w;

    always_comb
    begin
        cfg_w = EW'(width_reg);
        if (cfg_w < EW'(MIN_WIDTH))
        begin
            eff_w = EW'(MIN_WIDTH);
        end
        else if (cfg_w > EW'(MAX_WIDTH))
        begin
            eff_w = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = cfg_w;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake
    // ------------------------------------------------------------------
    logic s1_v_reg, s2_v_reg, s3_v_reg, out_v_reg;
    logic s1_emit_reg;
    logic out_ready, s3_ready, s2_ready, s1_ready;
    logic s3_fire, s2_fire, s1_fire, pix_fire;

    assign out_ready = !out_v_reg || !med_stall;
    assign s3_fire   = s3_v_reg && out_ready;
    assign s3_ready  = !s3_v_reg || out_ready;
    assign s2_fire   = s2_v_reg && s3_ready;
    assign s2_ready  = !s2_v_reg || s3_ready;
    assign s1_fire   = s1_v_reg && (!s1_emit_reg || s2_ready);
    assign s1_ready  = !s1_v_reg || s1_fire;
    assign pix_stall = !s1_ready;
    assign pix_fire  = pix_valid && s1_ready;

    // ------------------------------------------------------------------
    // Stage 0: position tracking and line buffer read
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_reg, col_next, cur_col;
    row_t             row_reg, row_next, cur_row;
    logic             line_end;
    logic             emit;

    always_comb
    begin
        cur_col  = frame_start ? '0 : col_reg;
        cur_row  = frame_start ? '0 : row_reg;
        line_end = (EW'(cur_col) + EW'(1)) >= eff_w;
        col_next = line_end ? '0 : cur_col + 1'b1;
        row_next = line_end ? cur_row + 1'b1 : cur_row;
        emit     = (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
    end

    // Advance the position on every taken pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (pix_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Line buffer: {upper row, middle row} per column
    // ------------------------------------------------------------------
    logic [2*PIX_W-1:0] ram_rdata;
    logic [2*PIX_W-1:0] ram_wdata;
    logic [COL_W-1:0]   s1_col_reg;
    pix_t               s1_px_reg;
    pix_t               s1_up, s1_mid;

    assign ram_wdata = {s1_mid, s1_px_reg};

    mf3_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_col_reg),
        .wdata (ram_wdata),
        .re    (pix_fire),
        .raddr (cur_col),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1: line buffer data, forwarding, window and write-back
    // ------------------------------------------------------------------
    row_t s1_row_reg;
    logic s1_fwd_reg;
    pix_t s1_fwd_up_reg, s1_fwd_mid_reg;
    logic fwd_hit;

    assign fwd_hit = s1_fire && (s1_col_reg == cur_col);
    assign s1_up   = s1_fwd_reg ? s1_fwd_up_reg  : ram_rdata[2*PIX_W-1:PIX_W];
    assign s1_mid  = s1_fwd_reg ? s1_fwd_mid_reg : ram_rdata[PIX_W-1:0];

    // Stage 1 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_v_reg <= pix_valid;
        end
    end

    // Stage 1 payload; catch the column being written back this cycle
    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            s1_px_reg      <= pixel;
            s1_col_reg     <= cur_col;
            s1_row_reg     <= cur_row;
            s1_emit_reg    <= emit;
            s1_fwd_reg     <= fwd_hit;
            s1_fwd_up_reg  <= s1_mid;
            s1_fwd_mid_reg <= s1_px_reg;
        end
    end

    // Shift the window by one column
    pix_t win_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_fire)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= s1_up;
            win_reg[4] <= s1_mid;
            win_reg[5] <= s1_px_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: each column sorted
    // ------------------------------------------------------------------
    col3_t s2_col_reg [3];
    row_t  s2_row_reg;
    ctr_t  s2_ctr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_v_reg <= s1_v_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_emit_reg)
        begin
            s2_col_reg[0] <= sort3(win_reg[0], win_reg[1], win_reg[2]);
            s2_col_reg[1] <= sort3(win_reg[3], win_reg[4], win_reg[5]);
            s2_col_reg[2] <= sort3(s1_up, s1_mid, s1_px_reg);
            s2_row_reg    <= s1_row_reg - 1'b1;
            s2_ctr_reg    <= CTR_W'(s1_col_reg - 1'b1);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: max of lows, median of middles, min of highs
    // ------------------------------------------------------------------
    pix_t s3_lo_reg, s3_mi_reg, s3_hi_reg;
    row_t s3_row_reg;
    ctr_t s3_ctr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            s3_lo_reg  <= max2(max2(s2_col_reg[0].lo, s2_col_reg[1].lo), s2_col_reg[2].lo);
            s3_mi_reg  <= med3(s2_col_reg[0].mi, s2_col_reg[1].mi, s2_col_reg[2].mi);
            s3_hi_reg  <= min2(min2(s2_col_reg[0].hi, s2_col_reg[1].hi), s2_col_reg[2].hi);
            s3_row_reg <= s2_row_reg;
            s3_ctr_reg <= s2_ctr_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: median of the three candidates
    // ------------------------------------------------------------------
    pix_t out_med_reg;
    row_t out_row_reg;
    ctr_t out_ctr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_fire)
        begin
            out_med_reg <= med3(s3_lo_reg, s3_mi_reg, s3_hi_reg);
            out_row_reg <= s3_row_reg;
            out_ctr_reg <= s3_ctr_reg;
        end
    end

    assign med_valid    = out_v_reg;
    assign median_value = out_med_reg;
    assign center_row   = out_row_reg;
    assign center_col   = out_ctr_reg;

`ifndef SYNTHESIS
    // A result never sits on the image border
    a_center_inside: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> (out_row_reg != '0) && (out_ctr_reg != '0))
        else $error("median result tagged with a border position");

    // Column steps by one or restarts at zero
    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        pix_fire && !frame_start |=>
            (col_reg == '0) || (col_reg == $past(col_reg) + 1'b1))
        else $error("column counter skipped");

    // Line buffer data holds while its pixel waits in stage 1
    a_rdata_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_v_reg && !s1_fire |=> $stable(ram_rdata))
        else $error("line buffer read data lost while stage 1 held");

    // A back-to-back access to the same column takes the forwarded data
    a_fwd_taken: assert property (@(posedge clk) disable iff (!rst_n)
        pix_fire && s1_fire && (s1_col_reg == cur_col) |=> s1_fwd_reg)
        else $error("same-column write-back not forwarded");
`endif

endmodule

// File: design/mf3_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module mf3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port; a read of the same entry in the same cycle returns the old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
